// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define TWG_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("twg assertion failed");

// Same, on the default clock and reset names
`define TWG_ASSERT(lbl, prop) `TWG_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== design/twg_pkg.sv =====
// Shared types, constants and the sine ROM builder of the test waveform generator
package twg_pkg;

    localparam int C_SINE_BITS    = 10;
    localparam int C_QTR_BITS     = C_SINE_BITS - 2;
    localparam int C_QTR_SIZE     = 1 << C_QTR_BITS;
    localparam int C_CODE_BITS    = 12;
    localparam int C_OUT_BITS     = ((C_CODE_BITS + 7) / 8) * 8;
    localparam int C_ADDR_BITS    = 5;
    localparam int C_QUEUE_DEPTH  = 4;
    localparam int C_QPTR_BITS    = $clog2(C_QUEUE_DEPTH);
    localparam int C_QCNT_BITS    = C_QPTR_BITS + 1;

    localparam logic [31:0] C_LCG_MUL   = 32'd1664525;
    localparam logic [31:0] C_LCG_ADD   = 32'd1013904223;
    localparam logic [15:0] C_DUTY_RST  = 16'd32768;
    localparam logic [17:0] C_GAIN_RST  = 18'd81316;
    localparam logic [31:0] C_SEED_RST  = 32'd1;

    typedef longint unsigned t_u64;

    // Q30 odd polynomial for sin(pi/2 * u), highest order last
    localparam t_u64 C_SIN_COEF [7] = '{
        64'd1686629713, 64'd693598668, 64'd85615204, 64'd5029682,
        64'd172363, 64'd3866, 64'd61
    };

    typedef enum logic [2:0] {
        REG_WAVE_SHAPE = 3'd0,
        REG_PHASE_STEP = 3'd1,
        REG_LOW_LEVEL  = 3'd2,
        REG_HIGH_LEVEL = 3'd3,
        REG_DUTY       = 3'd4,
        REG_NOISE_AMP  = 3'd5,
        REG_CODE_GAIN  = 3'd6,
        REG_NOISE_SEED = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2
    } t_shape;

    typedef struct packed {
        logic [1:0]         wave_shape;
        logic [31:0]        phase_step;
        logic signed [13:0] low_level_mv;
        logic signed [13:0] high_level_mv;
        logic [15:0]        duty_fraction;
        logic [9:0]         noise_amp_mv;
        logic [17:0]        code_gain;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } t_seed_load;

    typedef struct packed {
        logic [31:0] phase;
        logic [31:0] noise;
    } t_item;

    typedef logic [14:0] t_qtr_rom [C_QTR_SIZE];

    // sin(pi/2 * u), u in Q30, rounded to Q15 and held at 32767
    function automatic logic [14:0] quarter_sine(input t_u64 u);
        t_u64 u2;
        t_u64 s;
        u2 = (u * u) >> 30;
        s = C_SIN_COEF[6];
        for (int i = 5; i >= 0; i--) begin
            s = C_SIN_COEF[i] - ((s * u2) >> 30);
        end
        s = (s * u) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

    function automatic t_qtr_rom build_quarter_rom();
        t_qtr_rom rom;
        for (int m = 0; m < C_QTR_SIZE; m++) begin
            rom[m] = quarter_sine(t_u64'(m) << (32 - C_SINE_BITS));
        end
        return rom;
    endfunction

    localparam logic [14:0] C_SINE_PEAK = quarter_sine(t_u64'(1) << 30);

endpackage

// ===== design/twg_cfg.sv =====
// Configuration register bank with its register-bus port
module twg_cfg import twg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [C_ADDR_BITS-1:0] i_paddr,
    input  logic [31:0]            i_pwdata,
    output logic [31:0]            o_prdata,
    output logic                   o_pready,
    output t_cfg                   o_cfg,
    output t_seed_load             o_seed
);

    t_cfg        r_cfg;
    logic [31:0] r_seed;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[C_ADDR_BITS-1:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_shape    <= SHAPE_SINE;
            r_cfg.phase_step    <= '0;
            r_cfg.low_level_mv  <= '0;
            r_cfg.high_level_mv <= '0;
            r_cfg.duty_fraction <= C_DUTY_RST;
            r_cfg.noise_amp_mv  <= '0;
            r_cfg.code_gain     <= C_GAIN_RST;
            r_seed              <= C_SEED_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WAVE_SHAPE: r_cfg.wave_shape    <= i_pwdata[1:0];
                REG_PHASE_STEP: r_cfg.phase_step    <= i_pwdata;
                REG_LOW_LEVEL:  r_cfg.low_level_mv  <= signed'(i_pwdata[13:0]);
                REG_HIGH_LEVEL: r_cfg.high_level_mv <= signed'(i_pwdata[13:0]);
                REG_DUTY:       r_cfg.duty_fraction <= i_pwdata[15:0];
                REG_NOISE_AMP:  r_cfg.noise_amp_mv  <= i_pwdata[9:0];
                REG_CODE_GAIN:  r_cfg.code_gain     <= i_pwdata[17:0];
                REG_NOISE_SEED: r_seed              <= i_pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WAVE_SHAPE: o_prdata = {30'd0, r_cfg.wave_shape};
            REG_PHASE_STEP: o_prdata = r_cfg.phase_step;
            REG_LOW_LEVEL:  o_prdata = {18'd0, r_cfg.low_level_mv};
            REG_HIGH_LEVEL: o_prdata = {18'd0, r_cfg.high_level_mv};
            REG_DUTY:       o_prdata = {16'd0, r_cfg.duty_fraction};
            REG_NOISE_AMP:  o_prdata = {22'd0, r_cfg.noise_amp_mv};
            REG_CODE_GAIN:  o_prdata = {14'd0, r_cfg.code_gain};
            REG_NOISE_SEED: o_prdata = r_seed;
        endcase
    end

    assign o_cfg        = r_cfg;
    assign o_seed.load  = w_wr && (w_idx == REG_NOISE_SEED);
    assign o_seed.value = i_pwdata;

endmodule

// ===== design/twg_front.sv =====
// Front end: takes sample indexes, steps the noise sequence, forms the phase
module twg_front import twg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_index,
    output logic        o_ready,
    input  t_cfg        i_cfg,
    input  t_seed_load  i_seed,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);

    logic        r_valid;
    logic [31:0] r_index;
    logic [31:0] r_noise;
    logic [31:0] w_noise_next;
    logic [31:0] w_phase;
    logic        w_accept;

    assign o_ready      = !r_valid || !i_full;
    assign w_accept     = i_valid && o_ready;
    assign o_push       = r_valid && !i_full;
    assign w_noise_next = r_noise * C_LCG_MUL + C_LCG_ADD;
    assign w_phase      = r_index * i_cfg.phase_step;

    // r_noise always equals the noise value of the item held in this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_noise <= C_SEED_RST;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
            if (i_seed.load) begin
                r_noise <= i_seed.value;
            end else if (w_accept) begin
                r_noise <= w_noise_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_index <= i_index;
        end
    end

    assign o_item.phase = w_phase;
    assign o_item.noise = r_noise;

endmodule

// ===== design/twg_queue.sv =====
// Small FIFO between the front end and the back end
module twg_queue import twg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item                  r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_BITS-1:0] r_wr;
    logic [C_QPTR_BITS-1:0] r_rd;
    logic [C_QCNT_BITS-1:0] r_count;
    logic                   w_wr;
    logic                   w_rd;

    assign o_full  = (r_count == C_QCNT_BITS'(C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + C_QCNT_BITS'(w_wr) - C_QCNT_BITS'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== design/twg_back.sv =====
// Back end: shape, noise, gain, rounding and saturation in four register stages
module twg_back import twg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_empty,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [C_CODE_BITS-1:0] o_code,
    input  logic                   i_ready
);

    localparam t_qtr_rom    C_QTR_ROM    = build_quarter_rom();
    localparam logic [47:0] C_ROUND_HALF = 48'h8000_0000_0000;
    localparam logic [19:0] C_HI_MAX     = 20'((1 << C_CODE_BITS) - 1);

    typedef enum logic [1:0] {
        COMB_SINE     = 2'd0,
        COMB_TRI_UP   = 2'd1,
        COMB_TRI_DOWN = 2'd2
    } t_comb;

    logic w_en;

    // stage 1 signals
    logic [C_SINE_BITS-1:0] w_top;
    logic [1:0]             w_quad;
    logic [C_QTR_BITS-1:0]  w_m;
    logic [C_QTR_BITS-1:0]  w_m_mirror;
    logic [14:0]            w_mag;
    logic signed [15:0]     w_sine;
    logic signed [14:0]     w_diff;
    logic signed [47:0]     w_lo48;
    logic signed [47:0]     w_hi48;
    logic signed [31:0]     w_op_a;
    logic signed [47:0]     w_base;
    t_comb                  w_comb;
    logic signed [46:0]     w_prod;
    logic signed [23:0]     w_noise_c;
    logic signed [34:0]     w_noise_prod;

    logic               r1_valid;
    logic signed [47:0] r1_base;
    logic signed [46:0] r1_prod;
    t_comb              r1_comb;
    logic signed [34:0] r1_noise_prod;

    // stage 2 signals
    logic signed [47:0] w_p48;
    logic signed [47:0] w_term;
    logic signed [47:0] w_v;

    logic               r2_valid;
    logic signed [47:0] r2_v;

    // stage 3 signals
    logic signed [31:0] w_vh;
    logic [15:0]        w_vl;
    logic signed [50:0] w_pa;
    logic [33:0]        w_vl_g;
    logic [47:0]        w_pb;

    logic               r3_valid;
    logic signed [50:0] r3_pa;
    logic [31:0]        r3_pb;

    // output stage signals
    logic signed [51:0]     w_t;
    logic [19:0]            w_hi;
    logic [C_CODE_BITS-1:0] w_code;

    logic                   r_out_valid;
    logic [C_CODE_BITS-1:0] r_out_code;

    // the whole back end holds while a finished code waits downstream
    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && !i_empty;

    always_comb begin
        w_top      = i_item.phase[31 -: C_SINE_BITS];
        w_quad     = w_top[C_SINE_BITS-1 -: 2];
        w_m        = w_top[C_QTR_BITS-1:0];
        w_m_mirror = -w_m;
        // odd quadrants read the quarter wave backwards
        if (!w_quad[0]) begin
            w_mag = C_QTR_ROM[w_m];
        end else if (w_m == '0) begin
            w_mag = C_SINE_PEAK;
        end else begin
            w_mag = C_QTR_ROM[w_m_mirror];
        end
        w_sine = w_quad[1] ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});

        w_diff = i_cfg.high_level_mv - i_cfg.low_level_mv;
        w_lo48 = 48'(i_cfg.low_level_mv);
        w_hi48 = 48'(i_cfg.high_level_mv);

        unique case (i_cfg.wave_shape)
            SHAPE_SQUARE: begin
                w_op_a = '0;
                w_comb = COMB_TRI_UP;
                if (i_item.phase < {i_cfg.duty_fraction, 16'h0000}) begin
                    w_base = w_hi48 <<< 32;
                end else begin
                    w_base = w_lo48 <<< 32;
                end
            end
            SHAPE_TRIANGLE: begin
                // distance into the half period is the low 31 phase bits either way
                w_op_a = signed'({1'b0, i_item.phase[30:0]});
                if (i_item.phase[31]) begin
                    w_base = w_hi48 <<< 32;
                    w_comb = COMB_TRI_DOWN;
                end else begin
                    w_base = w_lo48 <<< 32;
                    w_comb = COMB_TRI_UP;
                end
            end
            default: begin
                w_op_a = 32'(w_sine);
                w_base = (w_lo48 + w_hi48) <<< 31;
                w_comb = COMB_SINE;
            end
        endcase

        w_prod       = w_op_a * w_diff;
        w_noise_c    = signed'({~i_item.noise[31], i_item.noise[30:8]});
        w_noise_prod = signed'({1'b0, i_cfg.noise_amp_mv}) * w_noise_c;
    end

    always_comb begin
        w_p48 = 48'(r1_prod);
        unique case (r1_comb)
            COMB_SINE:     w_term = w_p48 <<< 16;
            COMB_TRI_UP:   w_term = w_p48 <<< 1;
            COMB_TRI_DOWN: w_term = -(w_p48 <<< 1);
            default:       w_term = '0;
        endcase
        w_v = r1_base + w_term + (48'(r1_noise_prod) <<< 9);
    end

    // split v into a signed high part and an unsigned low part
    always_comb begin
        w_vh   = r2_v[47:16];
        w_vl   = r2_v[15:0];
        w_pa   = w_vh * signed'({1'b0, i_cfg.code_gain});
        w_vl_g = w_vl * i_cfg.code_gain;
        w_pb   = {14'd0, w_vl_g} + C_ROUND_HALF;
    end

    always_comb begin
        w_t  = 52'(r3_pa) + signed'({20'd0, r3_pb});
        w_hi = w_t[51:32];
        if (w_t[51]) begin
            w_code = '0;
        end else if (w_hi > C_HI_MAX) begin
            w_code = '1;
        end else begin
            w_code = w_hi[C_CODE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= !i_empty;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_base       <= w_base;
            r1_prod       <= w_prod;
            r1_comb       <= w_comb;
            r1_noise_prod <= w_noise_prod;
            r2_v          <= w_v;
            r3_pa         <= w_pa;
            r3_pb         <= w_pb[47:16];
            r_out_code    <= w_code;
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;

endmodule

// ===== design/test_waveform_generator_unit.sv =====
// Top level of the test waveform generator: register bank, front end, queue, back end
//
//  Channel   Direction  Handshake                 Payload
//  s_*       in         s_tvalid / s_tready       s_tdata[31:0] = sample_index
//  m_*       out        m_tvalid / m_tready       m_tdata[11:0] = adc_code, [15:12] zero
//  p*        in         psel, penable, pwrite     paddr = 4 * register index, pwdata
//
//  Sustained rate is one sample per clock; the front end takes a new index every cycle
//  the queue has room, and the back end moves one item per cycle while m_tready is high.
//  A result passes the front register, the queue and three back-end stages before the
//  output register.
//  The sine ROM is constant logic, so the block is ready right after reset (no clearing pass).
//  An output stall freezes the back end; the four-entry queue and the front register
//  absorb items until s_tready drops.
module test_waveform_generator_unit import twg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // stream in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] sample_index
    // stream out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [C_OUT_BITS-1:0]  m_tdata,   // [11:0] adc_code, rest zero
    // register bus
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [C_ADDR_BITS-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg                   w_cfg;
    t_seed_load             w_seed;
    logic                   w_push;
    logic                   w_full;
    t_item                  w_push_item;
    logic                   w_pop;
    logic                   w_empty;
    t_item                  w_head_item;
    logic [C_CODE_BITS-1:0] w_code;

    // register bank; a seed write also reloads the noise generator
    twg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg),
        .o_seed    (w_seed)
    );

    // front end: advance noise per transfer and form the phase
    twg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_index (s_tdata),
        .o_ready (s_tready),
        .i_cfg   (w_cfg),
        .i_seed  (w_seed),
        .o_push  (w_push),
        .o_item  (w_push_item),
        .i_full  (w_full)
    );

    // decouple the two halves so each can stall on its own
    twg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty)
    );

    // back end: waveform value, noise, gain, round and saturate
    twg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_empty (w_empty),
        .i_item  (w_head_item),
        .o_pop   (w_pop),
        .o_valid (m_tvalid),
        .o_code  (w_code),
        .i_ready (m_tready)
    );

    // pad the code with zeros to whole bytes
    assign m_tdata = {{(C_OUT_BITS - C_CODE_BITS){1'b0}}, w_code};

endmodule

// ===== design/twg_checker.sv =====
// Port-level checker for the test waveform generator and its bind
`include "assert_macros.svh"

module twg_checker import twg_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [C_OUT_BITS-1:0] m_tdata
);

    // front register, queue entries, and four back-end registers
    localparam int C_CAPACITY = 1 + C_QUEUE_DEPTH + 4;
    localparam int C_CNT_BITS = $clog2(C_CAPACITY + 2) + 1;

    logic [C_CNT_BITS-1:0] r_inflight;
    logic                  w_in;
    logic                  w_out;

    assign w_in  = s_tvalid && s_tready;
    assign w_out = m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + C_CNT_BITS'(w_in) - C_CNT_BITS'(w_out);
        end
    end

    `TWG_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    `TWG_ASSERT(a_out_pad, m_tvalid |-> (m_tdata[C_OUT_BITS-1:C_CODE_BITS] == '0))
    `TWG_ASSERT(a_no_phantom, m_tvalid |-> (r_inflight != '0))
    `TWG_ASSERT(a_capacity, r_inflight <= C_CNT_BITS'(C_CAPACITY))

endmodule

bind test_waveform_generator_unit twg_checker u_twg_checker (.*);

// ===== tb/test_waveform_generator_unit_tb.sv =====
// Testbench of the test waveform generator: random sample streams and register setups against a code predictor
module test_waveform_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twg_pkg::*;

    typedef longint unsigned u64_t;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ROUNDS = 12;
    localparam int          ROUND_ITEMS   = 160;
    localparam int          SETTLE_CYCLES = 10;   // output latency plus margin
    localparam int          HOLD_CYCLES   = 300;  // long receiver back-pressure
    localparam int          HOLD_AFTER    = 400;  // codes seen before that hold
    localparam int          REG_COUNT     = REG_NOISE_SEED + 1;
    localparam int          CODE_MAX      = (1 << C_CODE_BITS) - 1;
    localparam logic [1:0]  SHAPE_SPARE   = 2'd3; // unused code, behaves as sine
    localparam logic [31:0] NOISE_MUL     = 32'd1664525;
    localparam logic [31:0] NOISE_INC     = 32'd1013904223;

    // Q30 coefficients of the odd polynomial for sin(pi/2 * u), lowest order first
    localparam u64_t SINE_POLY [7] = '{
        64'd1686629713, 64'd693598668, 64'd85615204, 64'd5029682,
        64'd172363, 64'd3866, 64'd61
    };

    // Predicts the converter code of each accepted sample and checks the results in order
    class code_scoreboard;
        logic [1:0]            shape;
        logic [31:0]           step;
        longint                low_mv;
        longint                high_mv;
        logic [15:0]           duty;
        logic [9:0]            noise_amp;
        logic [17:0]           gain;
        logic [31:0]           noise_lcg;
        int                    sine_rom [1 << C_SINE_BITS];
        logic [C_OUT_BITS-1:0] expected_codes [$];
        int                    faults;
        int                    codes_checked;

        function new();
            u64_t u;
            u64_t u2;
            u64_t s;
            int   quarter;
            quarter = (1 << C_SINE_BITS) / 4;
            // Fill the full-wave table from the quarter-wave polynomial
            for (int k = 0; k < (1 << C_SINE_BITS); k++) begin
                u = u64_t'(k % quarter) << (32 - C_SINE_BITS);
                if ((k / quarter) % 2 == 1) begin
                    u = (u64_t'(1) << 30) - u;
                end
                u2 = (u * u) >> 30;
                s = SINE_POLY[6];
                for (int i = 5; i >= 0; i--) begin
                    s = SINE_POLY[i] - ((s * u2) >> 30);
                end
                s = (s * u) >> 30;
                s = (s + 16384) >> 15;
                if (s > 32767) begin
                    s = 32767;
                end
                sine_rom[k] = ((k / quarter) >= 2) ? -int'(s) : int'(s);
            end
            shape         = SHAPE_SINE;
            step          = 32'd0;
            low_mv        = 0;
            high_mv       = 0;
            duty          = 16'd32768;
            noise_amp     = 10'd0;
            gain          = 18'd81316;
            noise_lcg     = 32'd1;
            faults        = 0;
            codes_checked = 0;
        endfunction

        function void note_register(input t_reg_idx idx, input logic [31:0] value);
            case (idx)
                REG_WAVE_SHAPE: shape = value[1:0];
                REG_PHASE_STEP: step = value;
                REG_LOW_LEVEL:  low_mv = longint'(signed'(value[13:0]));
                REG_HIGH_LEVEL: high_mv = longint'(signed'(value[13:0]));
                REG_DUTY:       duty = value[15:0];
                REG_NOISE_AMP:  noise_amp = value[9:0];
                REG_CODE_GAIN:  gain = value[17:0];
                REG_NOISE_SEED: noise_lcg = value;
            endcase
        endfunction

        // Millivolt level in signed Q32, then gain, round half up, saturate
        function logic [C_OUT_BITS-1:0] predict_code(input logic [31:0] idx);
            logic [31:0] phase;
            longint      ph;
            longint      span;
            longint      level;
            longint      noise;
            longint      vh;
            longint      t;
            u64_t        vl;
            phase = idx * step;
            ph    = longint'({32'h0, phase});
            span  = high_mv - low_mv;
            case (shape)
                SHAPE_SQUARE: begin
                    level = (phase < {duty, 16'h0}) ? high_mv : low_mv;
                    level = level <<< 32;
                end
                SHAPE_TRIANGLE: begin
                    if (!phase[31]) begin
                        level = (low_mv <<< 32) + 2 * ph * span;
                    end else begin
                        level = (high_mv <<< 32) - 2 * (ph - (longint'(1) <<< 31)) * span;
                    end
                end
                default: begin
                    level = ((low_mv + high_mv) <<< 31)
                          + span * sine_rom[phase >> (32 - C_SINE_BITS)] * 65536;
                end
            endcase
            noise_lcg = noise_lcg * NOISE_MUL + NOISE_INC;
            noise = longint'({40'h0, noise_lcg[31:8]}) - 64'sd8388608;
            level += longint'({54'h0, noise_amp}) * noise * 512;
            // Split so that the gain product stays inside 64 bits
            vl = {48'h0, level[15:0]};
            vh = level >>> 16;
            t = vh * longint'({46'h0, gain})
              + longint'((vl * {46'h0, gain} + (u64_t'(1) << 47)) >> 16);
            if (t < 0) begin
                return '0;
            end
            t = t >>> 32;
            return (t > CODE_MAX) ? C_OUT_BITS'(CODE_MAX) : C_OUT_BITS'(t);
        endfunction

        function void note_sample(input logic [31:0] idx);
            expected_codes.push_back(predict_code(idx));
        endfunction

        function void note_fault(input string what, input logic [C_OUT_BITS-1:0] want,
                                 input logic [C_OUT_BITS-1:0] got);
            faults++;
            if (faults <= 10) begin
                $display("%0t: %s: expected code %0d, got %0d", $realtime, what, want, got);
            end
        endfunction

        function void check_code(input logic [C_OUT_BITS-1:0] got);
            logic [C_OUT_BITS-1:0] want;
            codes_checked++;
            if (expected_codes.size() == 0) begin
                note_fault("code with no sample pending", 'x, got);
            end else begin
                want = expected_codes.pop_front();
                if (got !== want) begin
                    note_fault("code mismatch", want, got);
                end
            end
        endfunction
    endclass

    // Block inputs start at known values
    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata  = '0;   // [31:0] sample_index
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [C_OUT_BITS-1:0]  m_tdata;         // [11:0] adc_code, rest zero
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [C_ADDR_BITS-1:0] paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    bit                     calm = 1'b0;     // no random gaps or stalls on either side while set
    logic [31:0]            setup_word [REG_COUNT];
    code_scoreboard         codes = new();

    test_waveform_generator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Millivolt level: extremes, the full range, or the usual 0..3.3 V span
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return -8192;
            1:       return 8191;
            2, 3:    return $urandom_range(0, 16383) - 8192;
            default: return $urandom_range(0, 3300);
        endcase
    endfunction

    function automatic void plan_setup(input logic [1:0] shape, input logic [31:0] step,
                                       input logic [31:0] low, input logic [31:0] high,
                                       input logic [15:0] duty, input logic [9:0] amp,
                                       input logic [17:0] gain, input logic [31:0] seed);
        setup_word[REG_WAVE_SHAPE] = {30'h0, shape};
        setup_word[REG_PHASE_STEP] = step;
        setup_word[REG_LOW_LEVEL]  = low;
        setup_word[REG_HIGH_LEVEL] = high;
        setup_word[REG_DUTY]       = {16'h0, duty};
        setup_word[REG_NOISE_AMP]  = {22'h0, amp};
        setup_word[REG_CODE_GAIN]  = {14'h0, gain};
        setup_word[REG_NOISE_SEED] = seed;
    endfunction

    // Write the planned registers back to back, the seed only on request; release the bus
    task automatic apply_setup(input bit load_seed);
        for (int r = REG_WAVE_SHAPE; r <= REG_NOISE_SEED; r++) begin
            if (r != REG_NOISE_SEED || load_seed) begin
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= {t_reg_idx'(r), 2'b00};
                pwdata  <= setup_word[r];
                @(posedge i_clk);
                penable <= 1'b1;
                do @(posedge i_clk); while (!pready);
                codes.note_register(t_reg_idx'(r), setup_word[r]);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one sample index, maybe after a gap, and hold it until the transfer
    task automatic send_sample(input logic [31:0] idx);
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles()) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop valid, drain every pending code, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (codes.expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random register setup; the first two rounds pin every register to an extreme
    task automatic choose_setup(input int round);
        logic [31:0] step;
        logic [15:0] duty;
        logic [9:0]  amp;
        logic [17:0] gain;
        if (round == 0) begin
            plan_setup(SHAPE_SPARE, 32'hFFFF_FFFF, 8191, 8191, 16'hFFFF, 10'd1023,
                       18'h3FFFF, 32'hFFFF_FFFF);
        end else if (round == 1) begin
            plan_setup(SHAPE_SINE, 32'h0, -8192, -8192, 16'h0, 10'd0, 18'h0, 32'h0);
        end else begin
            case ($urandom_range(0, 9))
                0:       step = 32'h0;
                1:       step = 32'hFFFF_FFFF;
                2, 3:    step = $urandom;
                default: step = $urandom_range(1, 32'h0400_0000);
            endcase
            case ($urandom_range(0, 9))
                0:       duty = 16'h0;
                1:       duty = 16'hFFFF;
                default: duty = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 9))
                0:          amp = 10'd0;
                1:          amp = 10'd1023;
                2, 3, 4, 5: amp = $urandom_range(0, 63);
                default:    amp = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 9))
                0:             gain = 18'h0;
                1:             gain = 18'h3FFFF;
                2, 3, 4, 5, 6: gain = 18'd81316;
                default:       gain = $urandom_range(0, 18'h3FFFF);
            endcase
            plan_setup($urandom_range(0, 3), step, pick_level(), pick_level(), duty, amp,
                       gain, $urandom);
        end
    endtask

    // Watch both streams: note each accepted index, check each accepted code
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            codes.note_sample(s_tdata);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            codes.check_code(m_tdata);
        end
    end

    // Receiver: random stalls, none in calm rounds, and one long hold so the queue
    // fills up and the block has to drop s_tready while samples keep coming
    initial begin : receiver
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!held && codes.codes_checked >= HOLD_AFTER) begin
                stall_left = HOLD_CYCLES;
                held       = 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = gap_cycles();
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Stop a hung run
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** test_waveform_generator_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] base;
        bit          in_order;
        // Hold reset at first, then release it for good
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setup: zero levels give code zero, noise still advances
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        wait_idle();

        // Full-scale sine at maximum gain: peak saturates high, trough clamps to zero
        plan_setup(SHAPE_SINE, 32'h0400_0000, -8192, 8191, 16'h0, 10'd0, 18'h3FFFF,
                   32'hFFFF_FFFF);
        apply_setup(1'b1);
        send_sample(32'd0);
        send_sample(32'd8);
        send_sample(32'd16);
        send_sample(32'd48);
        wait_idle();

        // Unused shape code falls back to the sine
        setup_word[REG_WAVE_SHAPE] = {30'h0, SHAPE_SPARE};
        apply_setup(1'b0);
        send_sample(32'd16);
        send_sample(32'd48);
        wait_idle();

        // Square at quarter duty: indexes on both sides of the edge
        plan_setup(SHAPE_SQUARE, 32'h0100_0000, 0, 1000, 16'd16384, 10'd0, 18'd81316, 32'h0);
        apply_setup(1'b0);
        send_sample(32'd0);
        send_sample(32'd63);
        send_sample(32'd64);
        send_sample(32'd255);
        wait_idle();

        // Square duty extremes: nearly always high, then always low
        setup_word[REG_DUTY] = 32'hFFFF;
        apply_setup(1'b0);
        send_sample(32'd255);
        wait_idle();
        setup_word[REG_DUTY] = 32'h0;
        apply_setup(1'b0);
        send_sample(32'd0);
        wait_idle();

        // Triangle: rising half, the turn at mid-cycle, falling half
        plan_setup(SHAPE_TRIANGLE, 32'h0200_0000, -500, 1500, 16'd32768, 10'd0, 18'd81316,
                   32'h0);
        apply_setup(1'b0);
        send_sample(32'd0);
        send_sample(32'd64);
        send_sample(32'd96);
        send_sample(32'd127);
        wait_idle();

        // Full noise with zero gain gives zero, then the same noise amplitude at maximum gain
        plan_setup(SHAPE_SINE, 32'h0, 0, 0, 16'd32768, 10'd1023, 18'h0, 32'd12345);
        apply_setup(1'b1);
        send_sample(32'd1);
        wait_idle();
        setup_word[REG_CODE_GAIN] = 32'h3FFFF;
        apply_setup(1'b0);
        send_sample(32'd2);
        send_sample(32'd3);
        wait_idle();

        // Random rounds: mostly running sample counts, some scattered indexes
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            choose_setup(round);
            calm = ($urandom_range(0, 3) == 0);
            apply_setup(round < 2 || $urandom_range(0, 1) == 1);
            base     = $urandom;
            in_order = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ROUND_ITEMS; k++) begin
                send_sample(in_order ? base + k : $urandom);
            end
            wait_idle();
        end

        if (codes.faults == 0 && codes.expected_codes.size() == 0) begin
            $display("** test_waveform_generator_unit: PASSED **");
        end else begin
            $display("** test_waveform_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/twg_pkg.sv
design/twg_cfg.sv
design/twg_front.sv
design/twg_queue.sv
design/twg_back.sv
design/test_waveform_generator_unit.sv
design/twg_checker.sv
tb/test_waveform_generator_unit_tb.sv
